// ===== rtl/core/ilpm_pkg.sv =====
// ilpm_pkg: shared types and constants for the inverted luma palette match core
// item structs for both channels, palette entry layout, opcodes and register indexes
// no dependencies
package ilpm_pkg;

  localparam int unsigned CfgWidth = 9;
  localparam int unsigned DistWidth = 18;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_GRAY_OFFSET  = 2'd0;
  localparam logic [1:0] REG_RED_WEIGHT   = 2'd1;
  localparam logic [1:0] REG_GREEN_WEIGHT = 2'd2;
  localparam logic [1:0] REG_BLUE_WEIGHT  = 2'd3;

  // reset values of the configuration registers
  localparam logic [8:0] GRAY_OFFSET_RST  = 9'd255;
  localparam logic [7:0] RED_WEIGHT_RST   = 8'd77;
  localparam logic [7:0] GREEN_WEIGHT_RST = 8'd150;
  localparam logic [7:0] BLUE_WEIGHT_RST  = 8'd29;

  typedef struct packed {
    logic       opcode;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] expected_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           gray_level;
    logic [7:0]           nearest_index;
    logic [DistWidth-1:0] best_distance;
    logic                 mismatch;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pal_entry_t;

  // status of a finished palette sweep
  typedef struct packed {
    logic                 done;
    logic [7:0]           index;
    logic [DistWidth-1:0] distance;
  } sweep_res_t;

endpackage

// ===== rtl/core/ilpm_palette_mem.sv =====
// ilpm_palette_mem: palette store, one write port and one registered read port
// depends on ilpm_pkg for the entry layout
module ilpm_palette_mem #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned AW = 8
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  ilpm_pkg::pal_entry_t wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output ilpm_pkg::pal_entry_t rd_data
);
  import ilpm_pkg::*;

  pal_entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/ilpm_luma.sv =====
// ilpm_luma: two-stage inverted luma unit, weighted products then sum, subtract and clamp
// depends on ilpm_pkg
module ilpm_luma (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [8:0] gray_offset,
  input  logic [7:0] red_weight,
  input  logic [7:0] green_weight,
  input  logic [7:0] blue_weight,
  output logic       gray_valid,
  output logic [7:0] gray
);
  import ilpm_pkg::*;

  logic        prod_valid;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic [7:0]  gray_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      gray_valid <= 1'b0;
    end else begin
      prod_valid <= start;
      gray_valid <= prod_valid;
    end
    prod_r <= red_weight * red;
    prod_g <= green_weight * green;
    prod_b <= blue_weight * blue;
    gray   <= gray_next;
  end

  always_comb begin
    logic [DistWidth-1:0] sum;
    logic [9:0]           luma;
    logic [9:0]           offs;
    logic [9:0]           diff;
    sum  = DistWidth'(prod_r) + DistWidth'(prod_g) + DistWidth'(prod_b);
    luma = sum[DistWidth-1:8];
    offs = {1'b0, gray_offset};
    diff = offs - luma;
    if (luma >= offs) begin
      gray_next = 8'd0;
    end else if (diff[9:8] != 2'b00) begin
      gray_next = 8'hFF;
    end else begin
      gray_next = diff[7:0];
    end
  end

endmodule

// ===== rtl/core/ilpm_sweep.sv =====
// ilpm_sweep: walks the palette one read a cycle and keeps the nearest entry
// depends on ilpm_pkg; drives the read port of ilpm_palette_mem
module ilpm_sweep #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned AW = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [7:0]            gray,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  ilpm_pkg::pal_entry_t  rd_data,
  output ilpm_pkg::sweep_res_t  res
);
  import ilpm_pkg::*;

  localparam logic [AW-1:0] LastAddr = AW'(ENTRIES - 1);

  logic                 busy;
  logic [AW-1:0]        addr;
  logic                 s1_valid;
  logic                 s1_last;
  logic [AW-1:0]        s1_idx;
  logic                 s2_valid;
  logic                 s2_last;
  logic [AW-1:0]        s2_idx;
  logic [DistWidth-1:0] s2_dist;
  logic [DistWidth-1:0] dist_next;
  logic [AW-1:0]        best_idx;
  logic [DistWidth-1:0] best_dist;
  logic                 done;

  assign rd_en   = busy;
  assign rd_addr = addr;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  always_comb begin
    dist_next = DistWidth'(sq_diff(rd_data.red, gray))
              + DistWidth'(sq_diff(rd_data.green, gray))
              + DistWidth'(sq_diff(rd_data.blue, gray));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      addr     <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        addr <= '0;
      end else if (busy) begin
        addr <= addr + 1'b1;
        if (addr == LastAddr) begin
          busy <= 1'b0;
        end
      end
      s1_valid <= busy;
      s2_valid <= s1_valid;
      done     <= s2_valid && s2_last;
    end
    s1_idx  <= addr;
    s1_last <= (addr == LastAddr);
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    s2_dist <= dist_next;
    // first entry always taken, later ones only when strictly closer
    if (s2_valid && ((s2_idx == '0) || (s2_dist < best_dist))) begin
      best_idx  <= s2_idx;
      best_dist <= s2_dist;
    end
  end

  assign res.done     = done;
  assign res.index    = 8'(best_idx);
  assign res.distance = best_dist;

  a_addr_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> addr <= LastAddr)
    else $error("sweep address beyond palette");
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s2_valid) && $past(s2_last))
    else $error("sweep done without last entry");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("sweep restarted while busy");

endmodule

// ===== rtl/core/inverted_luma_palette_match_core.sv =====
// inverted_luma_palette_match_core: top level, control sequencer, config registers
// and output register; instantiates ilpm_palette_mem, ilpm_luma and ilpm_sweep
// depends on ilpm_pkg
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+---------------------------
//   in       | in        | in_valid/stall   | in_item  (ilpm_pkg::in_item_t)
//   out      | out       | out_valid/stall  | out_item (ilpm_pkg::out_item_t)
//   cfg      | in        | cfg_we           | cfg_index, cfg_data
//
// a load item writes the palette memory on acceptance
// a map item passes two luma stages, then one palette memory read a cycle
// through a three-stage distance and minimum pipe
// the next item is taken once the result sits in the output register
// reset clears control and config regs; every entry must be loaded before mapping
// out_stall holds the result in the output register while new items are taken
module inverted_luma_palette_match_core #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ilpm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ilpm_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);
  import ilpm_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LUMA,
    S_SWEEP,
    S_WAIT_OUT
  } state_t;

  state_t     state;
  logic [8:0] gray_offset;
  logic [7:0] red_weight;
  logic [7:0] green_weight;
  logic [7:0] blue_weight;
  logic [7:0] expected;
  logic [7:0] gray_hold;
  logic       sweep_start;
  out_item_t  result;

  logic       in_accept;
  logic       map_start;
  logic       load_wr;
  logic       gray_valid;
  logic [7:0] gray;
  logic       rd_en;
  logic [AW-1:0] rd_addr;
  pal_entry_t rd_data;
  pal_entry_t wr_data;
  sweep_res_t res;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign map_start = in_accept && (in_item.opcode == OP_MAP);
  assign load_wr   = in_accept && (in_item.opcode == OP_LOAD)
                     && (32'(in_item.entry_index) < PALETTE_ENTRIES);
  assign wr_data   = '{red: in_item.red, green: in_item.green, blue: in_item.blue};

  ilpm_palette_mem #(
    .ENTRIES(PALETTE_ENTRIES),
    .AW     (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (load_wr),
    .wr_addr(AW'(in_item.entry_index)),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ilpm_luma u_luma (
    .clk         (clk),
    .rst         (rst),
    .start       (map_start),
    .red         (in_item.red),
    .green       (in_item.green),
    .blue        (in_item.blue),
    .gray_offset (gray_offset),
    .red_weight  (red_weight),
    .green_weight(green_weight),
    .blue_weight (blue_weight),
    .gray_valid  (gray_valid),
    .gray        (gray)
  );

  ilpm_sweep #(
    .ENTRIES(PALETTE_ENTRIES),
    .AW     (AW)
  ) u_sweep (
    .clk    (clk),
    .rst    (rst),
    .start  (sweep_start),
    .gray   (gray_hold),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .res    (res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gray_offset  <= GRAY_OFFSET_RST;
      red_weight   <= RED_WEIGHT_RST;
      green_weight <= GREEN_WEIGHT_RST;
      blue_weight  <= BLUE_WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAY_OFFSET:  gray_offset  <= cfg_data;
        REG_RED_WEIGHT:   red_weight   <= cfg_data[7:0];
        REG_GREEN_WEIGHT: green_weight <= cfg_data[7:0];
        REG_BLUE_WEIGHT:  blue_weight  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sweep_start <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      sweep_start <= (state == S_LUMA) && gray_valid;
      // the output wait state reloads the register itself
      if (out_valid && !out_stall && (state != S_WAIT_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (map_start) begin
            expected <= in_item.expected_index;
            state    <= S_LUMA;
          end
        end
        S_LUMA: begin
          if (gray_valid) begin
            gray_hold   <= gray;
            state       <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (res.done) begin
            result.gray_level    <= gray_hold;
            result.nearest_index <= res.index;
            result.best_distance <= res.distance;
            result.mismatch      <= (res.index != expected);
            state                <= S_WAIT_OUT;
          end
        end
        S_WAIT_OUT: begin
          if (!out_valid || !out_stall) begin
            out_item  <= result;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_map_enters_luma: assert property (@(posedge clk) disable iff (rst)
    map_start |=> state == S_LUMA)
    else $error("map item did not start luma");
  a_done_in_sweep: assert property (@(posedge clk) disable iff (rst)
    res.done |-> state == S_SWEEP)
    else $error("sweep result outside sweep state");
  a_out_from_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_WAIT_OUT)
    else $error("result raised outside output wait");
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !load_wr)
    else $error("palette written during sweep");

endmodule
